[hw/rtl/cdp_pkg.sv]
// ----------------------------------------------------------------------------
// cdp_pkg: shared definitions for the CSV decimal field parser
// Character codes, the byte classification type and the flag bundle that
// travels from the field engine to the result register.
// ----------------------------------------------------------------------------
package cdp_pkg;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Decimal weight of the accumulator step.
    localparam int unsigned RADIX = 10;

    typedef struct packed {
        logic is_digit;
        logic is_blank;
        logic is_minus;
        logic is_below_zero;
    } t_char_class;

    // Status of the field engine for the byte in the input register.
    typedef struct packed {
        logic emit;
        logic comma_ended;
        logic overflowed;
    } t_step_flags;

    function automatic t_char_class cdp_classify(input logic [7:0] b);
        t_char_class c;
        c.is_digit      = (b >= CH_ZERO) && (b <= CH_NINE);
        c.is_blank      = (b == CH_SPACE) || (b == CH_TAB);
        c.is_minus      = (b == CH_MINUS);
        c.is_below_zero = (b < CH_ZERO);
        return c;
    endfunction

endpackage

[hw/rtl/cdp_field_engine.sv]
// ----------------------------------------------------------------------------
// cdp_field_engine: per-byte field state and accumulator
// Holds the field phase, sign, magnitude and overflow flag, and works out
// the finished field for a terminating byte in a single pass.
// ----------------------------------------------------------------------------
module cdp_field_engine
    import cdp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_go,
    input  logic [7:0]             i_byte,
    output t_step_flags            o_flags,
    output logic [VALUE_WIDTH-1:0] o_value
);

    localparam int XW = VALUE_WIDTH + 4;
    localparam logic [VALUE_WIDTH-1:0] LIM = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic                   r_phase, n_phase;
    logic                   r_neg, n_neg;
    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic                   r_ovf, n_ovf;

    t_char_class            cls;
    logic [XW-1:0]          prod;
    logic                   acc_ovf;
    logic [VALUE_WIDTH-1:0] acc_mag;
    logic                   emit;
    logic                   pos_sat;

    assign cls = cdp_classify(i_byte);

    // Overflow test: magnitude*10 + digit beyond 2^(W-1) is the same as the
    // division-based limit check, and needs only a shift-add and a compare.
    assign prod = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1)
                + XW'(i_byte[3:0]);
    assign acc_ovf = prod > {4'b0, LIM};
    assign acc_mag = acc_ovf ? LIM : prod[VALUE_WIDTH-1:0];

    assign emit = r_phase ? !cls.is_digit
                          : !(cls.is_blank || cls.is_digit || cls.is_minus
                              || cls.is_below_zero);

    assign pos_sat = (r_mag == LIM);

    always_comb begin
        o_flags.emit        = emit;
        o_flags.comma_ended = (i_byte == CH_COMMA);
        if (r_neg) begin
            o_value            = '0 - r_mag;
            o_flags.overflowed = r_ovf;
        end else if (pos_sat) begin
            o_value            = ~LIM;
            o_flags.overflowed = 1'b1;
        end else begin
            o_value            = r_mag;
            o_flags.overflowed = r_ovf;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_ovf   = r_ovf;
        if (i_go) begin
            if (emit) begin
                n_phase = 1'b0;
                n_neg   = 1'b0;
                n_mag   = '0;
                n_ovf   = 1'b0;
            end else if (cls.is_digit) begin
                n_phase = 1'b1;
                n_mag   = acc_mag;
                n_ovf   = r_ovf | acc_ovf;
            end else if (!cls.is_blank) begin
                // Only reached at field start: a sign or a skipped byte.
                n_phase = 1'b1;
                n_neg   = r_neg | cls.is_minus;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_neg   <= 1'b0;
            r_mag   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
            r_ovf   <= n_ovf;
        end
    end

endmodule

[hw/rtl/cdp_result_reg.sv]
// ----------------------------------------------------------------------------
// cdp_result_reg: output register for finished fields
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module cdp_result_reg
    import cdp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [7:0]             i_end_byte,
    input  t_step_flags            i_flags,
    output logic                   o_can_load,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [7:0]             o_end_byte,
    output logic                   o_comma_ended,
    output logic                   o_overflowed
);

    logic                   r_vld;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [7:0]             r_end_byte;
    logic                   r_comma, r_ovf;

    assign o_can_load = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value    <= i_value;
            r_end_byte <= i_end_byte;
            r_comma    <= i_flags.comma_ended;
            r_ovf      <= i_flags.overflowed;
        end
    end

    assign o_valid       = r_vld;
    assign o_value       = r_value;
    assign o_end_byte    = r_end_byte;
    assign o_comma_ended = r_comma;
    assign o_overflowed  = r_ovf;

endmodule

[hw/rtl/csv_decimal_int_field_parser.sv]
// ----------------------------------------------------------------------------
// csv_decimal_int_field_parser: comma-separated signed integer field parser
//
//   Channel | Direction | Signals                                  | Meaning
//   --------+-----------+------------------------------------------+-----------
//   text    | in        | i_text_valid/o_text_ready, i_text_byte   | one byte
//   field   | out       | o_field_valid/i_field_ready, value, end  | one field
//
// Flow: a byte is taken into the input register and then processed by the
// field engine; one byte per cycle is sustained unless an end byte waits on
// a stalled field side. A finished field is loaded into the result register
// as its end byte leaves the input register. Reset is synchronous and active
// low; it clears the field state and both valid flags. A stall on the field
// side holds only a byte that ends a field; bytes that extend a field flow on.
// ----------------------------------------------------------------------------
module csv_decimal_int_field_parser
    import cdp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_text_valid,
    output logic                          o_text_ready,
    input  logic [7:0]                    i_text_byte,
    output logic                          o_field_valid,
    input  logic                          i_field_ready,
    output logic signed [VALUE_WIDTH-1:0] o_field_value,
    output logic [7:0]                    o_end_byte,
    output logic                          o_comma_ended,
    output logic                          o_overflowed
);

    // Input register: one byte waiting for the field engine.
    logic       r_in_vld;
    logic [7:0] r_in_byte;

    t_step_flags            flags;
    logic [VALUE_WIDTH-1:0] eng_value;
    logic [VALUE_WIDTH-1:0] out_value;
    logic                   can_load;
    logic                   go;
    logic                   load;

    // The held byte moves on unless it ends a field while the result
    // register is still occupied by a transaction nobody has taken.
    assign go           = r_in_vld && (!flags.emit || can_load);
    assign load         = go && flags.emit;
    assign o_text_ready = !r_in_vld || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_text_ready) begin
            r_in_vld <= i_text_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text_valid && o_text_ready) begin
            r_in_byte <= i_text_byte;
        end
    end

    cdp_field_engine #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_byte  (r_in_byte),
        .o_flags (flags),
        .o_value (eng_value)
    );

    cdp_result_reg #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_result (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_value       (eng_value),
        .i_end_byte    (r_in_byte),
        .i_flags       (flags),
        .o_can_load    (can_load),
        .o_valid       (o_field_valid),
        .i_ready       (i_field_ready),
        .o_value       (out_value),
        .o_end_byte    (o_end_byte),
        .o_comma_ended (o_comma_ended),
        .o_overflowed  (o_overflowed)
    );

    assign o_field_value = $signed(out_value);

    // The engine only advances on a byte that is actually held.
    a_go_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |-> r_in_vld)
        else $error("engine advanced without a held byte");

    // A finished field is never written over a result still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_field_valid && !i_field_ready) |=> !$past(load))
        else $error("result overwritten while stalled");

    // The comma flag always agrees with the delivered end byte.
    a_comma_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_field_valid |-> (o_comma_ended == (o_end_byte == CH_COMMA)))
        else $error("comma flag disagrees with end byte");

    // A positive saturated field carries the largest positive value.
    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_field_valid && o_overflowed && !o_field_value[VALUE_WIDTH-1])
        |-> (o_field_value == {1'b0, {(VALUE_WIDTH-1){1'b1}}}))
        else $error("positive overflow not saturated to the maximum");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the CSV decimal integer field parser
// A byte stream of directed and randomly built fields is pushed through the
// text channel in bursts. Each accepted byte is run through a behavioural
// predictor, and every field transaction leaving the block is compared with
// the oldest predicted field.
// ----------------------------------------------------------------------------
module tb;
    import cdp_pkg::*;

    localparam int          VW         = 32;
    localparam logic [63:0] NEG_LIMIT  = 64'd1 << (VW - 1);
    localparam int          TEXT_ITEMS = 600;
    localparam logic [7:0]  CH_NUL     = 8'h00;
    localparam logic [7:0]  CH_LF      = 8'h0A;
    localparam logic [7:0]  CH_CR      = 8'h0D;
    localparam logic [7:0]  CH_ALPHA   = 8'h41;
    localparam logic [7:0]  CH_BANG    = 8'h21;

    typedef struct packed {
        logic signed [VW-1:0] value;
        logic [7:0]           end_byte;
        logic                 comma_ended;
        logic                 overflowed;
    } field_t;

    // Predicts finished fields from the accepted bytes and checks the block's
    // field transactions against them in order.
    class field_scoreboard;
        field_t      expected_fields[$];
        bit          in_digits;
        bit          is_negative;
        bit          sat_seen;
        bit [63:0]   magnitude;
        int          fields_checked;
        int          mismatches;
        int          saturated;
        int          comma_fields;

        function void add_digit(input logic [7:0] digit);
            if (magnitude > (NEG_LIMIT - 64'(digit)) / 10) begin
                magnitude = NEG_LIMIT;
                sat_seen  = 1'b1;
            end else begin
                magnitude = magnitude * 10 + 64'(digit);
            end
        endfunction

        function void close_field(input logic [7:0] b);
            field_t      f;
            logic [63:0] m;
            m             = magnitude;
            f.overflowed  = sat_seen;
            if (is_negative) begin
                m = 64'd0 - m;
            end else if (m > NEG_LIMIT - 1) begin
                // A positive field cannot reach the negative limit.
                m            = NEG_LIMIT - 1;
                f.overflowed = 1'b1;
            end
            f.value       = m[VW-1:0];
            f.end_byte    = b;
            f.comma_ended = (b == CH_COMMA);
            expected_fields.push_back(f);
            in_digits   = 1'b0;
            is_negative = 1'b0;
            magnitude   = '0;
            sat_seen    = 1'b0;
        endfunction

        function void note_byte(input logic [7:0] b);
            bit is_digit;
            is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
            if (!in_digits) begin
                if (b == CH_SPACE || b == CH_TAB) begin
                    return;
                end
                if (is_digit) begin
                    add_digit(b - CH_ZERO);
                    in_digits = 1'b1;
                end else if (b == CH_MINUS) begin
                    is_negative = 1'b1;
                    in_digits   = 1'b1;
                end else if (b < CH_ZERO) begin
                    in_digits = 1'b1;
                end else begin
                    close_field(b);
                end
            end else if (is_digit) begin
                add_digit(b - CH_ZERO);
            end else begin
                close_field(b);
            end
        endfunction

        function void check_field(input field_t got);
            field_t want;
            if (expected_fields.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] unexpected field: value %0d end 0x%02h %s",
                             $realtime, got.value, got.end_byte,
                             $sformatf("comma %0b ovf %0b", got.comma_ended,
                                       got.overflowed));
                end
                return;
            end
            want = expected_fields.pop_front();
            fields_checked++;
            if (want.overflowed)  saturated++;
            if (want.comma_ended) comma_fields++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] field mismatch: expected value %0d end 0x%02h %s",
                             $realtime, want.value, want.end_byte,
                             $sformatf("comma %0b ovf %0b", want.comma_ended,
                                       want.overflowed));
                    $display("          got value %0d end 0x%02h comma %0b ovf %0b",
                             got.value, got.end_byte, got.comma_ended,
                             got.overflowed);
                end
            end
        endfunction

        function int pending();
            return expected_fields.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_text_valid;
    logic                 o_text_ready;
    logic [7:0]           i_text_byte;
    logic                 o_field_valid;
    logic                 i_field_ready = 1'b0;
    logic signed [VW-1:0] o_field_value;
    logic [7:0]           o_end_byte;
    logic                 o_comma_ended;
    logic                 o_overflowed;

    field_scoreboard sb = new();
    logic [7:0]      text_q[$];
    logic [11:0]     rx_cycle = '0;
    int              bytes_sent;

    csv_decimal_int_field_parser #(
        .VALUE_WIDTH(VW)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_text_valid  (i_text_valid),
        .o_text_ready  (o_text_ready),
        .i_text_byte   (i_text_byte),
        .o_field_valid (o_field_valid),
        .i_field_ready (i_field_ready),
        .o_field_value (o_field_value),
        .o_end_byte    (o_end_byte),
        .o_comma_ended (o_comma_ended),
        .o_overflowed  (o_overflowed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs on either channel.
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // The receiver cycles through four stall patterns: always ready, mostly
    // ready, mostly stalled, and a short periodic ready window.
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        case (rx_cycle[9:8])
            2'd0: begin
                i_field_ready <= 1'b1;
            end
            2'd1: begin
                i_field_ready <= ($urandom_range(0, 3) != 0);
            end
            2'd2: begin
                i_field_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                i_field_ready <= (rx_cycle[4:0] < 5'd6);
            end
        endcase
    end

    // Every field transaction is checked at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_field_valid && i_field_ready) begin
            sb.check_field('{o_field_value, o_end_byte, o_comma_ended, o_overflowed});
        end
    end

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endtask

    task automatic push_decimal(input longint unsigned v);
        logic [7:0]        digits[$];
        longint unsigned   r;
        r = v;
        do begin
            digits.push_front(CH_ZERO + 8'(r % 10));
            r = r / 10;
        end while (r != 0);
        foreach (digits[i]) text_q.push_back(digits[i]);
    endtask

    // Builds one random field: mostly well-formed with random content, the
    // rest broken signs and noise bytes.
    task automatic push_random_field();
        int         kind;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            repeat ($urandom_range(0, 2)) begin
                text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            end
            if ($urandom_range(0, 1)) text_q.push_back(CH_MINUS);
            case ($urandom_range(0, 7))
                0: push_decimal(64'($urandom_range(0, 9)));
                1: push_decimal(64'($urandom_range(0, 99999)));
                2: push_decimal(64'($urandom));
                3: push_decimal(NEG_LIMIT - 1 + 64'($urandom_range(0, 2)));
                4: begin
                    repeat ($urandom_range(10, 14)) begin
                        text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    end
                end
                5: begin
                    repeat ($urandom_range(1, 3)) text_q.push_back(CH_ZERO);
                    push_decimal(64'($urandom_range(0, 999)));
                end
                6: push_decimal({$urandom, $urandom});
                default: push_decimal(64'($urandom_range(0, 999)));
            endcase
        end else if (kind < 85) begin
            // Sign with no digits, sometimes repeated.
            text_q.push_back(CH_MINUS);
            if ($urandom_range(0, 1)) text_q.push_back(CH_MINUS);
        end else begin
            repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 9) < 7) begin
            text_q.push_back(CH_COMMA);
        end else begin
            do begin
                b = 8'($urandom_range(0, 255));
            end while (b >= CH_ZERO && b <= CH_NINE);
            text_q.push_back(b);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        i_text_valid <= 1'b1;
        i_text_byte  <= b;
        @(posedge i_clk);
        while (!o_text_ready) @(posedge i_clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic idle_text(input int n);
        @(negedge i_clk);
        i_text_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    initial begin
        int burst_left;
        int wait_cycles;

        i_rst_n       = 1'b0;
        i_text_valid  = 1'b0;
        i_text_byte   = '0;
        bytes_sent    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: blanks, sign and leading zero before a comma, a high
        // byte at field start, a lone sign, a repeated sign, a skipped byte
        // below '0', and NUL, CR, LF and 0xFF as terminators.
        push_text(" \t-07,");
        text_q.push_back(CH_ALPHA);
        push_text("-,");
        push_text("--");
        text_q.push_back(CH_BANG);
        push_text("5");
        text_q.push_back(CH_CR);
        push_text("3");
        text_q.push_back(8'hFF);
        text_q.push_back(CH_NUL);
        text_q.push_back(CH_NUL);
        push_text("00");
        text_q.push_back(CH_LF);

        while (text_q.size() < TEXT_ITEMS + 21) push_random_field();

        burst_left = $urandom_range(1, 40);
        foreach (text_q[i]) begin
            send_byte(text_q[i]);
            burst_left--;
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0) idle_text($urandom_range(1, 8));
                burst_left = $urandom_range(1, 40);
            end
        end
        @(negedge i_clk);
        i_text_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        // Let any stray transaction show up before the verdict.
        wait_cycles = 20;
        repeat (wait_cycles) @(posedge i_clk);

        $display("Run covered %0d text bytes and %0d field transactions", bytes_sent,
                 sb.fields_checked);
        $display("(%0d comma-terminated, %0d saturated), under bursty input and output stalls.",
                 sb.comma_fields, sb.saturated);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/cdp_pkg.sv
hw/rtl/cdp_field_engine.sv
hw/rtl/cdp_result_reg.sv
hw/rtl/csv_decimal_int_field_parser.sv
dv/tb.sv
